@@ rtl/circular_linked_deque_assert.svh @@
// Assertion macros for the circular linked deque
`ifndef CIRCULAR_LINKED_DEQUE_ASSERT_SVH
`define CIRCULAR_LINKED_DEQUE_ASSERT_SVH
// Implication checked on every clock edge outside reset
`define CLD_ASSERT_IMPL(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
// Implication checked in the following cycle
`define CLD_ASSERT_NEXT(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`endif

@@ rtl/cld_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cld_pkg
// Types, codes and defaults shared by the circular linked deque.
// ---------------------------------------------------------------------------
package cld_pkg;
    localparam int DefCapacity = 16;
    localparam int ValueW      = 32;
    localparam int LenW        = 5;

    typedef enum logic [2:0] {
        ACT_CREATE = 3'd0, ACT_DISPLAY = 3'd1, ACT_PUSH_FRONT = 3'd2,
        ACT_PUSH_BACK = 3'd3, ACT_POP_FRONT = 3'd4, ACT_POP_BACK = 3'd5,
        ACT_DEL_AFTER = 3'd6, ACT_CLEAR = 3'd7
    } t_action;

    typedef enum logic [1:0] {
        ST_OK = 2'd0, ST_EMPTY = 2'd1, ST_FULL = 2'd2, ST_NOTFOUND = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE, S_RD_HEAD, S_INS_RD, S_INS_WR, S_POP_RD, S_POP_WR,
        S_SRCH_RD, S_SRCH_CHK, S_DEL_RD, S_DEL_WR, S_DISP_RD, S_DISP_OUT, S_RESP
    } t_state;

    // Controller commands to the datapath
    typedef struct packed {
        logic    latch_in;   // capture action and value
        logic    ptr_head;   // r_ptr <= head
        logic    ptr_next;   // r_ptr <= next of read node
        logic    ptr_prev;   // r_ptr <= prev of read node
        logic    do_insert;  // write new node and neighbor links
        logic    do_unlink;  // unlink node at r_ptr
        logic    do_clear;   // drop every element
        logic    load_out;   // load output register
        logic    out_disp;   // output carries the read element
        logic    out_last;
        t_status status;
    } t_cmd;

    typedef struct packed {
        t_action action;
        logic    empty;
        logic    single;
        logic    full;
        logic    match;      // read element equals value
        logic    next_is_head;
        logic    disp_done;  // shown count plus one reaches length
        logic    out_busy;
    } t_stat;
endpackage

@@ rtl/cld_if.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cld_if
// Valid/ready channel carrying a generic payload.
// ---------------------------------------------------------------------------
interface cld_if #(parameter type T = logic) (input logic i_clk);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/circular_linked_deque.sv @@
`timescale 1ns / 1ps
// One action at a time; the next is accepted once the controller is idle again after its final result.
// Reset: synchronous active low; empties the list; stores keep stale data.
// ---------------------------------------------------------------------------
// circular_linked_deque
// Bounded circular doubly linked list with deque and search actions.
// ---------------------------------------------------------------------------
`include "circular_linked_deque_assert.svh"
module circular_linked_deque import cld_pkg::*; #(
    parameter int Capacity = DefCapacity
) (
    input  logic i_clk,
    input  logic i_rst_n,
    cld_if.sink   i_in,
    cld_if.source o_out
);
    t_cmd  w_cmd;
    t_stat w_stat;
    logic  w_in_ready;

    assign i_in.ready = w_in_ready;

    cld_ctrl u_ctrl (.i_clk, .i_rst_n, .i_in_valid(i_in.valid), .o_in_ready(w_in_ready),
        .i_stat(w_stat), .o_cmd(w_cmd));

    cld_datapath #(.Capacity(Capacity)) u_dp (.i_clk, .i_rst_n, .i_cmd(w_cmd),
        .o_stat(w_stat), .i_action(i_in.data.action), .i_value(i_in.data.value),
        .o_out_valid(o_out.valid), .i_out_ready(o_out.ready),
        .o_element(o_out.data.element), .o_status(o_out.data.status),
        .o_length(o_out.data.length), .o_last(o_out.data.last));

    `CLD_ASSERT_IMPL(a_no_accept_busy, i_clk, i_rst_n, w_cmd.load_out, !i_in.ready)
    `CLD_ASSERT_NEXT(a_load_valid, i_clk, i_rst_n, w_cmd.load_out, o_out.valid)
    `CLD_ASSERT_IMPL(a_one_write, i_clk, i_rst_n, w_cmd.do_insert, !w_cmd.do_unlink)
endmodule

@@ rtl/cld_ram.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cld_ram
// Single write port, single registered read port RAM.
// ---------------------------------------------------------------------------
module cld_ram #(
    parameter int Width = 32,
    parameter int Depth = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule

@@ rtl/cld_datapath.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cld_datapath
// Node stores, free map, head, count, pointers and the output register.
// ---------------------------------------------------------------------------
module cld_datapath import cld_pkg::*; #(
    parameter int Capacity = DefCapacity
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    output t_stat             o_stat,
    input  logic [2:0]        i_action,
    input  logic [ValueW-1:0] i_value,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [ValueW-1:0] o_element,
    output logic [1:0]        o_status,
    output logic [LenW-1:0]   o_length,
    output logic              o_last
);
    localparam int AW = $clog2(Capacity);
    localparam int CW = $clog2(Capacity + 1);

    logic [2:0]        r_action;
    logic [ValueW-1:0] r_value;
    logic [AW-1:0]     r_head, r_ptr, r_aux;
    logic [CW-1:0]     r_count, r_shown;
    logic [Capacity-1:0] r_used;
    logic [ValueW-1:0] w_elem;
    logic [AW-1:0]     w_next, w_prev;
    logic [AW-1:0]     w_free;
    logic              w_has_free;

    // Link write ports: each store gets one write per cycle; an insert into a nonempty
    // list and an unlink each write in two phases, phase 1 writing a neighbor's link.
    logic              n_we_d, n_we_n, n_we_p;
    logic [AW-1:0]     n_wa_d, n_wa_n, n_wa_p, n_wd_n, n_wd_p;
    logic [AW-1:0]     r_rd_addr;
    logic              r_phase;
    logic [AW-1:0]     r_tail;  // prev of the node at r_ptr, staged for second write

    cld_ram #(.Width(ValueW), .Depth(Capacity)) u_elem (.i_clk, .i_we(n_we_d),
        .i_waddr(n_wa_d), .i_wdata(r_value), .i_raddr(r_rd_addr), .o_rdata(w_elem));
    cld_ram #(.Width(AW), .Depth(Capacity)) u_next (.i_clk, .i_we(n_we_n),
        .i_waddr(n_wa_n), .i_wdata(n_wd_n), .i_raddr(r_rd_addr), .o_rdata(w_next));
    cld_ram #(.Width(AW), .Depth(Capacity)) u_prev (.i_clk, .i_we(n_we_p),
        .i_waddr(n_wa_p), .i_wdata(n_wd_p), .i_raddr(r_rd_addr), .o_rdata(w_prev));

    always_comb begin
        w_free = '0;
        w_has_free = 1'b0;
        for (int i = Capacity - 1; i >= 0; i--) begin
            if (!r_used[i]) begin
                w_free = AW'(i);
                w_has_free = 1'b1;
            end
        end
    end

    // Insert (nonempty list): ptr holds head, w_prev its tail (read already). Phase 0 writes
    // new node data/next/prev; phase 1 writes tail.next and head.prev.
    // Unlink: ptr holds victim, w_next/w_prev its links. Phase 0 writes
    // prev.next; phase 1 writes next.prev.
    always_comb begin
        n_we_d = 1'b0; n_we_n = 1'b0; n_we_p = 1'b0;
        n_wa_d = w_free; n_wa_n = w_free; n_wa_p = w_free;
        n_wd_n = r_ptr; n_wd_p = w_prev;
        if (i_cmd.do_insert) begin
            if (r_count == '0) begin
                n_we_d = !r_phase; n_we_n = !r_phase; n_we_p = !r_phase;
                n_wa_d = '0; n_wa_n = '0; n_wa_p = '0;
                n_wd_n = '0; n_wd_p = '0;
            end else if (!r_phase) begin
                n_we_d = 1'b1; n_we_n = 1'b1; n_we_p = 1'b1;
                n_wd_n = r_ptr; n_wd_p = w_prev;
            end else begin
                n_we_n = 1'b1; n_wa_n = r_tail; n_wd_n = w_free;
                n_we_p = 1'b1; n_wa_p = r_ptr;  n_wd_p = w_free;
            end
        end else if (i_cmd.do_unlink) begin
            if (!r_phase) begin
                n_we_n = 1'b1; n_wa_n = w_prev; n_wd_n = w_next;
            end else begin
                n_we_p = 1'b1; n_wa_p = r_aux; n_wd_p = r_tail;
            end
        end
    end

    logic [AW-1:0] n_rd_addr;
    always_comb begin
        n_rd_addr = r_ptr;
        if (i_cmd.ptr_head)      n_rd_addr = r_head;
        else if (i_cmd.ptr_next) n_rd_addr = w_next;
        else if (i_cmd.ptr_prev) n_rd_addr = w_prev;
    end

    always_ff @(posedge i_clk) begin
        r_rd_addr <= n_rd_addr;
        if (i_cmd.latch_in) begin
            r_action <= i_action;
            r_value  <= i_value;
        end
        if ((i_cmd.do_insert || i_cmd.do_unlink) && !r_phase) begin
            r_tail <= w_prev;
            if (i_cmd.do_unlink) r_aux <= w_next;
        end
        if (i_cmd.load_out) begin
            o_element <= i_cmd.out_disp ? w_elem : '0;
            o_last    <= i_cmd.out_last;
            o_status  <= i_cmd.status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0; r_ptr <= '0; r_count <= '0; r_used <= '0;
            r_phase <= 1'b0; r_shown <= '0; o_out_valid <= 1'b0; o_length <= '0;
        end else begin
            r_ptr <= n_rd_addr;
            if (i_cmd.latch_in) r_shown <= '0;
            if (i_cmd.load_out) begin
                o_out_valid <= 1'b1;
                o_length    <= LenW'(r_count);
                if (i_cmd.out_disp) r_shown <= r_shown + 1'b1;
            end else if (o_out_valid && i_out_ready) begin
                o_out_valid <= 1'b0;
            end
            if (i_cmd.do_clear) begin
                r_used <= '0; r_head <= '0; r_count <= '0;
            end
            if (i_cmd.do_insert) begin
                if (r_count == '0) begin
                    r_phase <= 1'b0;
                    r_used[0] <= 1'b1; r_head <= '0; r_count <= CW'(1);
                end else begin
                    r_phase <= !r_phase;
                    if (r_phase) begin
                        r_used[w_free] <= 1'b1;
                        r_count <= r_count + 1'b1;
                        if (r_action == ACT_PUSH_FRONT || r_action == ACT_CREATE)
                            r_head <= w_free;
                    end
                end
            end
            if (i_cmd.do_unlink) begin
                r_phase <= !r_phase;
                if (r_phase) begin
                    r_used[r_ptr] <= 1'b0;
                    r_count <= r_count - 1'b1;
                    if (r_ptr == r_head) r_head <= r_aux;
                end
            end
        end
    end

    assign o_stat.action       = t_action'(r_action);
    assign o_stat.empty        = (r_count == '0);
    assign o_stat.single       = (r_count == CW'(1));
    assign o_stat.full         = !w_has_free;
    assign o_stat.match        = (w_elem == r_value);
    assign o_stat.next_is_head = (w_next == r_head);
    assign o_stat.disp_done    = (r_shown + 1'b1 == r_count);
    assign o_stat.out_busy     = o_out_valid && !i_out_ready;
endmodule

@@ rtl/cld_ctrl.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cld_ctrl
// Action sequencer for the circular linked deque.
// ---------------------------------------------------------------------------
module cld_ctrl import cld_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);
    t_state  r_state, n_state;
    t_status r_st, n_st;
    logic    r_ph, n_ph;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_st <= ST_OK; r_ph <= 1'b0;
        end else begin
            r_state <= n_state; r_st <= n_st; r_ph <= n_ph;
        end
    end

    assign o_in_ready = (r_state == S_IDLE) && i_rst_n;

    always_comb begin
        n_state = r_state;
        n_st = r_st;
        n_ph = r_ph;
        unique case (r_state)
            S_IDLE: if (i_in_valid) n_state = S_RD_HEAD;
            S_RD_HEAD: begin
                n_st = ST_OK; n_ph = 1'b0;
                unique case (i_stat.action)
                    ACT_CREATE, ACT_CLEAR: n_state = (i_stat.action == ACT_CREATE)
                        ? S_INS_RD : S_RESP;
                    ACT_DISPLAY: begin
                        if (i_stat.empty) begin n_st = ST_EMPTY; n_state = S_RESP; end
                        else n_state = S_DISP_RD;
                    end
                    ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
                        if (!i_stat.empty && i_stat.full) begin
                            n_st = ST_FULL; n_state = S_RESP;
                        end else n_state = S_INS_RD;
                    end
                    ACT_POP_FRONT, ACT_POP_BACK: begin
                        if (i_stat.empty) begin n_st = ST_EMPTY; n_state = S_RESP; end
                        else n_state = S_POP_RD;
                    end
                    ACT_DEL_AFTER: begin
                        if (i_stat.empty) begin n_st = ST_EMPTY; n_state = S_RESP; end
                        else n_state = S_SRCH_RD;
                    end
                endcase
            end
            S_INS_RD:   n_state = S_INS_WR;
            S_INS_WR:   if (i_stat.empty || r_ph) n_state = S_RESP; else n_ph = 1'b1;
            // Read the head node, clearing a single element; then step to the victim (prev of head for pop back)
            S_POP_RD: begin
                if (!r_ph) begin
                    if (i_stat.single) n_state = S_RESP;
                    else n_ph = 1'b1;
                end else begin
                    n_ph = 1'b0; n_state = S_DEL_RD;
                end
            end
            S_SRCH_RD:  n_state = S_SRCH_CHK;
            S_SRCH_CHK: begin
                if (i_stat.next_is_head) begin n_st = ST_NOTFOUND; n_state = S_RESP; end
                else if (i_stat.match) n_state = S_DEL_RD;
                else n_state = S_SRCH_RD;
            end
            S_DEL_RD:   n_state = S_DEL_WR;
            S_DEL_WR:   if (r_ph) n_state = S_RESP; else n_ph = 1'b1;
            S_DISP_RD:  n_state = S_DISP_OUT;
            S_DISP_OUT: if (!i_stat.out_busy)
                n_state = i_stat.disp_done ? S_IDLE : S_DISP_RD;
            S_RESP:     if (!i_stat.out_busy) n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        o_cmd.status = r_st;
        unique case (r_state)
            S_IDLE:    o_cmd.latch_in = i_in_valid;
            S_RD_HEAD: begin
                o_cmd.ptr_head = 1'b1;
                if (i_stat.action == ACT_CREATE || i_stat.action == ACT_CLEAR)
                    o_cmd.do_clear = 1'b1;
            end
            S_INS_RD:  o_cmd.ptr_head = 1'b1;
            S_INS_WR:  o_cmd.do_insert = 1'b1;
            S_POP_RD: begin
                if (!r_ph) begin
                    if (i_stat.single) o_cmd.do_clear = 1'b1;
                end else if (i_stat.action == ACT_POP_BACK) begin
                    o_cmd.ptr_prev = 1'b1;
                end
            end
            S_SRCH_RD: ;
            S_SRCH_CHK: if (!i_stat.next_is_head) o_cmd.ptr_next = 1'b1;
            S_DEL_RD:  ;
            S_DEL_WR:  o_cmd.do_unlink = 1'b1;
            S_DISP_RD: ;
            S_DISP_OUT: if (!i_stat.out_busy) begin
                o_cmd.load_out = 1'b1; o_cmd.out_disp = 1'b1;
                o_cmd.out_last = i_stat.disp_done; o_cmd.status = ST_OK;
                o_cmd.ptr_next = !i_stat.disp_done;
            end
            S_RESP: if (!i_stat.out_busy) begin
                o_cmd.load_out = 1'b1; o_cmd.out_last = 1'b1;
            end
            default: ;
        endcase
    end
endmodule
